// ===== design/cir_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// cir_pkg
// Shared types and constants of the collision impulse resolver.
// ---------------------------------------------------------------------------
package cir_pkg;

	localparam int VEL_W  = 32;
	localparam int NRM_W  = 18;
	localparam int IM_W   = 31;
	localparam int RST_W  = 17;
	localparam int DEN_W  = 32;
	localparam int J_W    = 46;
	localparam int J_HALF = 23;
	localparam int IMP_W  = 32;

	typedef struct packed {
		logic signed [VEL_W-1:0] vax;
		logic signed [VEL_W-1:0] vay;
		logic signed [VEL_W-1:0] vbx;
		logic signed [VEL_W-1:0] vby;
		logic signed [NRM_W-1:0] nx;
		logic signed [NRM_W-1:0] ny;
		logic [IM_W-1:0]         ima;
		logic [IM_W-1:0]         imb;
		logic                    sep;
	} ctx_t;

endpackage
`default_nettype wire

// ===== design/cir_div_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// cir_div_cell
// One restoring division cell: produces one quotient bit and passes the
// partial remainder, the shifting dividend/quotient word and the contact on.
// ---------------------------------------------------------------------------
module cir_div_cell #(
	parameter int NUM_W = 54
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          en,
	input  wire                          in_valid,
	input  wire [cir_pkg::DEN_W-1:0]     in_rem,
	input  wire [NUM_W-1:0]              in_dq,
	input  wire [cir_pkg::DEN_W-1:0]     in_den,
	input  cir_pkg::ctx_t                in_ctx,
	output logic                         out_valid,
	output logic [cir_pkg::DEN_W-1:0]    out_rem,
	output logic [NUM_W-1:0]             out_dq,
	output logic [cir_pkg::DEN_W-1:0]    out_den,
	output cir_pkg::ctx_t                out_ctx
);

	logic [cir_pkg::DEN_W:0] trial;
	logic [cir_pkg::DEN_W:0] diff;
	logic                    ge;

	always_comb begin
		trial = {in_rem, in_dq[NUM_W-1]};
		diff  = trial - {1'b0, in_den};
		ge    = trial >= {1'b0, in_den};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_rem <= ge ? diff[cir_pkg::DEN_W-1:0] : trial[cir_pkg::DEN_W-1:0];
			out_dq  <= {in_dq[NUM_W-2:0], ge};
			out_den <= in_den;
			out_ctx <= in_ctx;
		end
	end

endmodule
`default_nettype wire

// ===== design/cir_imp_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// cir_imp_unit
// Scales the impulse by the normal and the inverse masses and applies the
// saturated velocity changes if not separating; holds the output register.
// ---------------------------------------------------------------------------
module cir_imp_unit #(
	parameter int FRAC_BITS = 16
) (
	input  wire                            clk,
	input  wire                            arst_n,
	input  wire                            en,
	input  wire                            in_valid,
	input  wire [cir_pkg::J_W-1:0]         in_j,
	input  cir_pkg::ctx_t                  in_ctx,
	output logic                           out_valid,
	output logic [cir_pkg::VEL_W-1:0]      out_vax,
	output logic [cir_pkg::VEL_W-1:0]      out_vay,
	output logic [cir_pkg::VEL_W-1:0]      out_vbx,
	output logic [cir_pkg::VEL_W-1:0]      out_vby,
	output logic                           out_sep
);

	localparam int PW = cir_pkg::J_HALF + cir_pkg::NRM_W;
	localparam int DW = cir_pkg::IMP_W + cir_pkg::IM_W - FRAC_BITS;
	localparam int SW = 65;

	function automatic logic [cir_pkg::VEL_W-1:0] sat_apply(
		input logic signed [cir_pkg::VEL_W-1:0] v,
		input logic [DW-1:0] d,
		input logic pos
	);
		logic signed [SW-1:0] vw;
		logic signed [SW-1:0] dw;
		logic signed [SW-1:0] s;
		vw = {{(SW-cir_pkg::VEL_W){v[cir_pkg::VEL_W-1]}}, v};
		dw = {{(SW-DW){1'b0}}, d};
		s  = pos ? vw + dw : vw - dw;
		if (s > $signed({{(SW-cir_pkg::VEL_W+1){1'b0}}, {(cir_pkg::VEL_W-1){1'b1}}})) begin
			return {1'b0, {(cir_pkg::VEL_W-1){1'b1}}};
		end else if (s < $signed({{(SW-cir_pkg::VEL_W+1){1'b1}},
				{(cir_pkg::VEL_W-1){1'b0}}})) begin
			return {1'b1, {(cir_pkg::VEL_W-1){1'b0}}};
		end
		return s[cir_pkg::VEL_W-1:0];
	endfunction

	logic [cir_pkg::NRM_W-1:0] nxm, nym;
	logic [PW-1:0] lox_s1, hix_s1, loy_s1, hiy_s1;
	cir_pkg::ctx_t ctx_s1, ctx_s2, ctx_s3;
	logic v_s1, v_s2, v_s3;
	logic [63:0] fx, fy, shx, shy;
	logic [cir_pkg::IMP_W-1:0] ipx_s2, ipy_s2;
	logic [63:0] pax, pay, pbx, pby;
	logic [DW-1:0] dax_s3, day_s3, dbx_s3, dby_s3;

	always_comb begin
		nxm = in_ctx.nx[cir_pkg::NRM_W-1] ? -in_ctx.nx : in_ctx.nx;
		nym = in_ctx.ny[cir_pkg::NRM_W-1] ? -in_ctx.ny : in_ctx.ny;
		fx  = ({{(64-PW){1'b0}}, hix_s1} << cir_pkg::J_HALF) + {{(64-PW){1'b0}}, lox_s1};
		fy  = ({{(64-PW){1'b0}}, hiy_s1} << cir_pkg::J_HALF) + {{(64-PW){1'b0}}, loy_s1};
		shx = fx >> FRAC_BITS;
		shy = fy >> FRAC_BITS;
		pax = {32'b0, ipx_s2} * {33'b0, ctx_s2.ima};
		pay = {32'b0, ipy_s2} * {33'b0, ctx_s2.ima};
		pbx = {32'b0, ipx_s2} * {33'b0, ctx_s2.imb};
		pby = {32'b0, ipy_s2} * {33'b0, ctx_s2.imb};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1      <= 1'b0;
			v_s2      <= 1'b0;
			v_s3      <= 1'b0;
			out_valid <= 1'b0;
		end else if (en) begin
			v_s1      <= in_valid;
			v_s2      <= v_s1;
			v_s3      <= v_s2;
			out_valid <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			lox_s1 <= {{cir_pkg::NRM_W{1'b0}}, in_j[cir_pkg::J_HALF-1:0]} *
				{{cir_pkg::J_HALF{1'b0}}, nxm};
			hix_s1 <= {{cir_pkg::NRM_W{1'b0}}, in_j[cir_pkg::J_W-1:cir_pkg::J_HALF]} *
				{{cir_pkg::J_HALF{1'b0}}, nxm};
			loy_s1 <= {{cir_pkg::NRM_W{1'b0}}, in_j[cir_pkg::J_HALF-1:0]} *
				{{cir_pkg::J_HALF{1'b0}}, nym};
			hiy_s1 <= {{cir_pkg::NRM_W{1'b0}}, in_j[cir_pkg::J_W-1:cir_pkg::J_HALF]} *
				{{cir_pkg::J_HALF{1'b0}}, nym};
			ctx_s1 <= in_ctx;
			ipx_s2 <= (|shx[63:cir_pkg::IMP_W]) ? '1 : shx[cir_pkg::IMP_W-1:0];
			ipy_s2 <= (|shy[63:cir_pkg::IMP_W]) ? '1 : shy[cir_pkg::IMP_W-1:0];
			ctx_s2 <= ctx_s1;
			dax_s3 <= DW'(pax >> FRAC_BITS);
			day_s3 <= DW'(pay >> FRAC_BITS);
			dbx_s3 <= DW'(pbx >> FRAC_BITS);
			dby_s3 <= DW'(pby >> FRAC_BITS);
			ctx_s3 <= ctx_s2;
			out_sep <= ctx_s3.sep;
			if (ctx_s3.sep) begin
				out_vax <= ctx_s3.vax;
				out_vay <= ctx_s3.vay;
				out_vbx <= ctx_s3.vbx;
				out_vby <= ctx_s3.vby;
			end else begin
				out_vax <= sat_apply(ctx_s3.vax, dax_s3, ctx_s3.nx[cir_pkg::NRM_W-1]);
				out_vay <= sat_apply(ctx_s3.vay, day_s3, ctx_s3.ny[cir_pkg::NRM_W-1]);
				out_vbx <= sat_apply(ctx_s3.vbx, dbx_s3, !ctx_s3.nx[cir_pkg::NRM_W-1]);
				out_vby <= sat_apply(ctx_s3.vby, dby_s3, !ctx_s3.ny[cir_pkg::NRM_W-1]);
			end
		end
	end

endmodule
`default_nettype wire

// ===== design/collision_impulse_resolver_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// collision_impulse_resolver_core
// Linear impulse response of one 2D contact in signed fixed point.
//
// Channel  Dir  Transfer            Payload
// s_*      in   s_tvalid&s_tready   one contact (tdata)
// m_*      out  m_tvalid&m_tready   resolved velocities (tdata), separating (tuser)
//
// One contact enters per cycle while the output is not stalled. The row of
// division cells gives one quotient bit per cell (NUM_W = 52 - FRAC_BITS + fac
// width). The whole pipeline advances while the output register is empty or
// drained; a stalled output holds every stage. Reset clears only the valid bits.
// ---------------------------------------------------------------------------
module collision_impulse_resolver_core #(
	parameter int FRAC_BITS = 16
) (
	input  wire          clk,
	input  wire          arst_n,
	input  wire          s_tvalid,
	output logic         s_tready,
	// vel_a_x, vel_a_y, vel_b_x, vel_b_y, normal_x, normal_y, inv_mass_a,
	// inv_mass_b, restitution_a, restitution_b, zero fill
	input  wire [263:0]  s_tdata,
	output logic         m_tvalid,
	input  wire          m_tready,
	// new_vel_a_x, new_vel_a_y, new_vel_b_x, new_vel_b_y
	output logic [127:0] m_tdata,
	// separating
	output logic [0:0]   m_tuser
);

	localparam int VN_W  = 52;
	localparam int VMW   = VN_W - FRAC_BITS;
	localparam int FW    = ((FRAC_BITS + 1 > cir_pkg::RST_W) ? FRAC_BITS + 1 : cir_pkg::RST_W) + 1;
	localparam int NUM_W = VMW + FW;
	localparam int QX    = (NUM_W > cir_pkg::J_W) ? NUM_W : cir_pkg::J_W + 1;

	logic adv;
	cir_pkg::ctx_t ctx_in, ctx_s1, ctx_s2, ctx_s3, ctx_s4;
	cir_pkg::ctx_t ctx_mid;
	logic v_s1, v_s2, v_s3, v_s4;
	logic signed [32:0] dx_s1, dy_s1;
	logic signed [50:0] px_s2, py_s2;
	logic [cir_pkg::RST_W-1:0] ra_s1, rb_s1, ra_s2, rb_s2, e;
	logic signed [VN_W-1:0] vn;
	logic [VN_W-1:0] vabs;
	logic [VMW-1:0] vmag_s3;
	logic [FW-1:0] fac_s3;
	logic [cir_pkg::DEN_W-1:0] den, den_s3, den_s4;
	logic [NUM_W-1:0] num_s4;

	logic                       cv   [0:NUM_W];
	logic [cir_pkg::DEN_W-1:0]  crem [0:NUM_W];
	logic [NUM_W-1:0]           cdq  [0:NUM_W];
	logic [cir_pkg::DEN_W-1:0]  cden [0:NUM_W];
	cir_pkg::ctx_t              cctx [0:NUM_W];

	logic [QX-1:0] qx;
	logic [cir_pkg::J_W-1:0] j;
	logic [cir_pkg::VEL_W-1:0] ovax, ovay, ovbx, ovby;
	logic osep;

	assign adv      = !m_tvalid || m_tready;
	assign s_tready = adv;

	always_comb begin
		ctx_in.vax = s_tdata[31:0];
		ctx_in.vay = s_tdata[63:32];
		ctx_in.vbx = s_tdata[95:64];
		ctx_in.vby = s_tdata[127:96];
		ctx_in.nx  = s_tdata[145:128];
		ctx_in.ny  = s_tdata[163:146];
		ctx_in.ima = s_tdata[194:164];
		ctx_in.imb = s_tdata[225:195];
		ctx_in.sep = 1'b0;
		vn   = {px_s2[50], px_s2} + {py_s2[50], py_s2};
		vabs = vn[VN_W-1] ? -vn : vn;
		ctx_mid     = ctx_s2;
		ctx_mid.sep = !vn[VN_W-1] && (vn != '0);
		e    = (ra_s2 < rb_s2) ? ra_s2 : rb_s2;
		den  = {1'b0, ctx_s2.ima} + {1'b0, ctx_s2.imb};
		if (den == '0) begin
			den = cir_pkg::DEN_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (adv) begin
			v_s1 <= s_tvalid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ctx_s1 <= ctx_in;
			dx_s1  <= {ctx_in.vbx[31], ctx_in.vbx} - {ctx_in.vax[31], ctx_in.vax};
			dy_s1  <= {ctx_in.vby[31], ctx_in.vby} - {ctx_in.vay[31], ctx_in.vay};
			ra_s1  <= s_tdata[242:226];
			rb_s1  <= s_tdata[259:243];
			ctx_s2 <= ctx_s1;
			px_s2  <= dx_s1 * ctx_s1.nx;
			py_s2  <= dy_s1 * ctx_s1.ny;
			ra_s2  <= ra_s1;
			rb_s2  <= rb_s1;
			ctx_s3     <= ctx_mid;
			vmag_s3    <= vabs[VN_W-1:FRAC_BITS];
			fac_s3     <= FW'(1 << FRAC_BITS) + FW'(e);
			den_s3     <= den;
			ctx_s4 <= ctx_s3;
			num_s4 <= {{FW{1'b0}}, vmag_s3} * {{VMW{1'b0}}, fac_s3};
			den_s4 <= den_s3;
		end
	end

	assign cv[0]   = v_s4;
	assign crem[0] = '0;
	assign cdq[0]  = num_s4;
	assign cden[0] = den_s4;
	assign cctx[0] = ctx_s4;

	for (genvar i = 0; i < NUM_W; i++) begin : g_div
		cir_div_cell #(
			.NUM_W(NUM_W)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (adv),
			.in_valid (cv[i]),
			.in_rem   (crem[i]),
			.in_dq    (cdq[i]),
			.in_den   (cden[i]),
			.in_ctx   (cctx[i]),
			.out_valid(cv[i+1]),
			.out_rem  (crem[i+1]),
			.out_dq   (cdq[i+1]),
			.out_den  (cden[i+1]),
			.out_ctx  (cctx[i+1])
		);
	end

	always_comb begin
		qx = QX'(cdq[NUM_W]);
		j  = (|(qx >> cir_pkg::J_W)) ? '1 : qx[cir_pkg::J_W-1:0];
	end

	cir_imp_unit #(
		.FRAC_BITS(FRAC_BITS)
	) u_imp (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (adv),
		.in_valid (cv[NUM_W]),
		.in_j     (j),
		.in_ctx   (cctx[NUM_W]),
		.out_valid(m_tvalid),
		.out_vax  (ovax),
		.out_vay  (ovay),
		.out_vbx  (ovbx),
		.out_vby  (ovby),
		.out_sep  (osep)
	);

	assign m_tdata    = {ovby, ovbx, ovay, ovax};
	assign m_tuser[0] = osep;

	a_stall_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |-> !s_tready)
		else $error("input taken while the output is stalled");

	a_accept_enters: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> v_s1)
		else $error("accepted contact did not enter the first stage");

	a_sep_passes: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && cv[NUM_W] && cctx[NUM_W].sep) |=> adv[->3] ##1
		(m_tuser[0] && m_tvalid))
		else $error("separating contact lost its flag");

endmodule
`default_nettype wire

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench
// Self-checking bench for collision_impulse_resolver_core. Contacts are
// driven on the input stream, and each resolved contact is compared field by
// field with the response that an independent fixed-point impulse calculation
// predicts. Directed corner contacts run first, then random traffic under
// several idle and stall patterns, with one long output hold-off.
// ---------------------------------------------------------------------------
module testbench;

	typedef struct packed {
		logic signed [31:0] vax;
		logic signed [31:0] vay;
		logic signed [31:0] vbx;
		logic signed [31:0] vby;
		logic signed [17:0] nx;
		logic signed [17:0] ny;
		logic [30:0]        ima;
		logic [30:0]        imb;
		logic [16:0]        ra;
		logic [16:0]        rb;
	} contact_t;

	typedef struct packed {
		logic [31:0] ax;
		logic [31:0] ay;
		logic [31:0] bx;
		logic [31:0] by;
		logic        sep;
	} response_t;

	logic         clk;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	logic [263:0] s_tdata;
	logic         m_tvalid;
	logic         m_tready;
	logic [127:0] m_tdata;
	logic [0:0]   m_tuser;

	response_t pending_responses[$];
	int        error_count;
	int        source_idle_pct;
	int        sink_stall_pct;
	int        hold_request;
	int        hold_left;
	int        quiet_cycles;

	localparam int QUIET_LIMIT = 20000;

	collision_impulse_resolver_core dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic longint unsigned velocity_change(longint unsigned j,
			longint unsigned nmag, longint unsigned inv);
		longint unsigned ip;
		ip = (j * nmag) >> 16;
		if (ip > 64'hFFFF_FFFF)
			ip = 64'hFFFF_FFFF;
		return (ip * inv) >> 16;
	endfunction

	function automatic logic [31:0] clamp_velocity(longint v);
		if (v > 64'sd2147483647)
			return 32'h7FFF_FFFF;
		if (v < -64'sd2147483648)
			return 32'h8000_0000;
		return v[31:0];
	endfunction

	function automatic response_t resolve_contact(contact_t c);
		response_t       r;
		longint          vax, vay, vbx, vby, nx, ny, vn;
		longint          oax, oay, obx, oby;
		longint unsigned e, vmag, den, j, nxm, nym, ima, imb;
		vax = c.vax; vay = c.vay; vbx = c.vbx; vby = c.vby;
		nx = c.nx; ny = c.ny;
		ima = c.ima; imb = c.imb;
		vn = (vbx - vax) * nx + (vby - vay) * ny;
		oax = vax; oay = vay; obx = vbx; oby = vby;
		r.sep = 1'b0;
		if (vn > 0) begin
			r.sep = 1'b1;
		end else begin
			e = (c.ra < c.rb) ? c.ra : c.rb;
			vmag = longint'(-vn) >> 16;
			den = ima + imb;
			if (den == 0)
				den = 1;
			j = (vmag * (64'd65536 + e)) / den;
			if (j > 64'h3FFF_FFFF_FFFF)
				j = 64'h3FFF_FFFF_FFFF;
			nxm = (nx < 0) ? -nx : nx;
			nym = (ny < 0) ? -ny : ny;
			if (nx < 0) begin
				oax = vax + longint'(velocity_change(j, nxm, ima));
				obx = vbx - longint'(velocity_change(j, nxm, imb));
			end else begin
				oax = vax - longint'(velocity_change(j, nxm, ima));
				obx = vbx + longint'(velocity_change(j, nxm, imb));
			end
			if (ny < 0) begin
				oay = vay + longint'(velocity_change(j, nym, ima));
				oby = vby - longint'(velocity_change(j, nym, imb));
			end else begin
				oay = vay - longint'(velocity_change(j, nym, ima));
				oby = vby + longint'(velocity_change(j, nym, imb));
			end
		end
		r.ax = clamp_velocity(oax);
		r.ay = clamp_velocity(oay);
		r.bx = clamp_velocity(obx);
		r.by = clamp_velocity(oby);
		return r;
	endfunction

	task automatic send_contact(contact_t c);
		while ($urandom_range(99) < source_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {4'b0, c.rb, c.ra, c.imb, c.ima, c.ny, c.nx,
			c.vby, c.vbx, c.vay, c.vax};
		do
			@(posedge clk);
		while (!s_tready);
		pending_responses = {pending_responses, resolve_contact(c)};
	endtask

	always @(posedge clk) begin
		response_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_responses.size() == 0) begin
				$display("%0t: unexpected transfer, actual %h / %b", $time, m_tdata,
					m_tuser);
				error_count++;
			end else begin
				want = pending_responses.pop_front();
				if (m_tdata[31:0] !== want.ax) begin
					$display("%0t: new_vel_a_x expected %h actual %h", $time, want.ax,
						m_tdata[31:0]);
					error_count++;
				end
				if (m_tdata[63:32] !== want.ay) begin
					$display("%0t: new_vel_a_y expected %h actual %h", $time, want.ay,
						m_tdata[63:32]);
					error_count++;
				end
				if (m_tdata[95:64] !== want.bx) begin
					$display("%0t: new_vel_b_x expected %h actual %h", $time, want.bx,
						m_tdata[95:64]);
					error_count++;
				end
				if (m_tdata[127:96] !== want.by) begin
					$display("%0t: new_vel_b_y expected %h actual %h", $time, want.by,
						m_tdata[127:96]);
					error_count++;
				end
				if (m_tuser[0] !== want.sep) begin
					$display("%0t: separating expected %b actual %b", $time, want.sep,
						m_tuser[0]);
					error_count++;
				end
			end
		end
		if (hold_request > 0) begin
			hold_left    = hold_request;
			hold_request = 0;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= sink_stall_pct);
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	function automatic logic [31:0] random_velocity();
		case ($urandom_range(3))
			0: return $urandom;
			1: return 32'($signed($urandom_range(1 << 21)) - (1 << 20));
			2: return 32'($signed($urandom_range(1 << 25)) - (1 << 24));
			default: return 32'($signed($urandom_range(1 << 17)) - (1 << 16));
		endcase
	endfunction

	function automatic logic [17:0] random_normal();
		case ($urandom_range(5))
			0: return 18'($urandom);
			1: return 18'(65536);
			2: return -18'sd65536;
			3: return 18'd0;
			default: return 18'($signed($urandom_range(131072)) - 65536);
		endcase
	endfunction

	function automatic logic [30:0] random_inv_mass();
		case ($urandom_range(4))
			0: return 31'd0;
			1: return 31'($urandom);
			default: return 31'($urandom_range(1 << 18));
		endcase
	endfunction

	function automatic logic [16:0] random_restitution();
		if ($urandom_range(4) == 0)
			return 17'($urandom);
		return 17'($urandom_range(65536));
	endfunction

	function automatic contact_t random_contact();
		contact_t c;
		c.vax = random_velocity();
		c.vay = random_velocity();
		c.vbx = random_velocity();
		c.vby = random_velocity();
		c.nx  = random_normal();
		c.ny  = random_normal();
		c.ima = random_inv_mass();
		c.imb = random_inv_mass();
		c.ra  = random_restitution();
		c.rb  = random_restitution();
		return c;
	endfunction

	task automatic test_directed();
		contact_t c;
		source_idle_pct = 0;
		sink_stall_pct  = 0;
		c = '0;
		send_contact(c);
		// Head-on approach along x with equal unit masses.
		c = '{32'sh0001_0000, 0, -32'sh0001_0000, 0, 18'sd65536, 0,
			31'h10000, 31'h10000, 17'h10000, 17'h8000};
		send_contact(c);
		// Already separating.
		c = '{-32'sh0001_0000, 0, 32'sh0001_0000, 0, 18'sd65536, 0,
			31'h10000, 31'h10000, 17'h10000, 17'h10000};
		send_contact(c);
		// Sliding along the contact: zero normal speed gives zero impulse.
		c = '{0, 32'sh0005_0000, 0, -32'sh0003_0000, 18'sd65536, 0,
			31'h10000, 31'h10000, 17'h10000, 17'h10000};
		send_contact(c);
		// Both bodies immovable.
		c = '{32'sh0002_0000, 32'sh0001_0000, -32'sh0002_0000, 0, 0, -18'sd65536,
			0, 0, 17'h10000, 17'h10000};
		send_contact(c);
		// Extreme velocities: outputs saturate; with both inverse masses zero the impulse saturates too.
		c = '{32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh8000_0000,
			18'sd65536, 18'sd65536, 31'h7FFF_FFFF, 0, 17'h1FFFF, 17'h1FFFF};
		send_contact(c);
		c = '{32'sh8000_0000, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
			-18'sd131072, -18'sd131072, 0, 31'h7FFF_FFFF, 17'h1FFFF, 17'h1FFFF};
		send_contact(c);
		c = '{32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh8000_0000, 32'sh7FFF_FFFF,
			18'sd131071, -18'sd131072, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 0, 0};
		send_contact(c);
		c = '{32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh8000_0000,
			18'sd65536, 18'sd65536, 0, 0, 17'h1FFFF, 0};
		send_contact(c);
		// Oblique normal, zero and full restitution.
		c = '{32'sh0003_0000, 32'sh0002_0000, 0, 0, 18'sd46341, 18'sd46341,
			31'h8000, 31'h20000, 0, 17'h10000};
		send_contact(c);
		c = '{32'sh0003_0000, 32'sh0002_0000, 0, 0, -18'sd46341, 18'sd46341,
			31'h8000, 31'h20000, 17'h10000, 17'h10000};
		send_contact(c);
		c = '{32'shFFFF_FFFF, 32'shFFFF_FFFF, 1, 1, 18'sd1, 18'sd1,
			1, 1, 1, 17'h1FFFF};
		send_contact(c);
		for (int i = 0; i < 8; i++)
			send_contact(random_contact());
	endtask

	task automatic test_random(int count, int idle_pct, int stall_pct);
		source_idle_pct = idle_pct;
		sink_stall_pct  = stall_pct;
		for (int i = 0; i < count; i++)
			send_contact(random_contact());
	endtask

	task automatic test_output_hold();
		source_idle_pct = 0;
		sink_stall_pct  = 0;
		hold_request    = 400;
		for (int i = 0; i < 200; i++)
			send_contact(random_contact());
	endtask

	initial begin
		error_count     = 0;
		source_idle_pct = 0;
		sink_stall_pct  = 0;
		hold_request    = 0;
		hold_left       = 0;
		quiet_cycles    = 0;
		arst_n          = 1'b0;
		s_tvalid        = 1'b0;
		s_tdata         = '0;
		m_tready        = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random(400, 0, 0);
		test_random(300, 85, 0);
		test_random(300, 0, 85);
		test_random(300, 33, 33);
		test_output_hold();
		test_random(200, 0, 0);
		s_tvalid <= 1'b0;
		while (pending_responses.size() != 0)
			@(posedge clk);
		repeat (200) @(posedge clk);
		if (error_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
